// ----- rtl/lcd_mtc_pkg.sv -----
// ============================================================================
// LCD mode timing controller package
// Timing constants, mode codes and the result word type.
// ============================================================================
package lcd_mtc_pkg;

    localparam int unsigned CountW = 10;
    localparam int unsigned LineW  = 8;

    localparam logic [CountW-1:0] LINE_CYCLES  = 10'd456;
    localparam logic [CountW-1:0] OAM_END      = 10'd80;
    localparam logic [CountW-1:0] TRANSFER_END = 10'd252;
    localparam logic [LineW-1:0]  VBLANK_LINE  = 8'd144;
    localparam logic [LineW-1:0]  LAST_LINE    = 8'd153;

    localparam logic [1:0] CFG_DISPLAY_ENABLE = 2'd0;
    localparam logic [1:0] CFG_COMPARE_LINE   = 2'd1;
    localparam logic [1:0] CFG_IRQ_ENABLES    = 2'd2;

    localparam int unsigned EN_HBLANK = 0;
    localparam int unsigned EN_VBLANK = 1;
    localparam int unsigned EN_OAM    = 2;
    localparam int unsigned EN_COIN   = 3;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    typedef struct packed {
        lcd_mode_t        lcd_mode;
        logic [LineW-1:0] current_line;
        logic             coincidence;
        logic             status_irq;
        logic             vblank_irq;
        logic             draw_strobe;
        logic [LineW-1:0] drawn_line;
    } result_t;

endpackage

// ----- rtl/lcd_mode_timing_controller_unit.sv -----
// ============================================================================
// LCD mode timing controller
// A result word is registered in the main output register, or in the skid register while the main one is stalled.
// Throughput: one word per cycle while the skid entry is empty, set by the single countdown subtract/compare.
// A two-entry output buffer lets one more input word in while a result is stalled.
// Reset (synchronous, active low) clears timing state and restores registers.
// ============================================================================
module lcd_mode_timing_controller_unit
    import lcd_mtc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_elapsed_cycles,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_lcd_mode,
    output logic [LineW-1:0] m_current_line,
    output logic             m_coincidence,
    output logic             m_status_irq,
    output logic             m_vblank_irq,
    output logic             m_draw_strobe,
    output logic [LineW-1:0] m_drawn_line
);

    logic              display_enable_reg;
    logic [LineW-1:0]  compare_line_reg;
    logic [3:0]        irq_enables_reg;

    logic [CountW-1:0] countdown_reg, countdown_next;
    logic [LineW-1:0]  line_reg, line_next;
    lcd_mode_t         prev_mode_reg, prev_mode_next;

    result_t           main_reg, skid_reg, result_next;
    logic              main_valid_reg, skid_valid_reg;

    logic              accept;
    logic              take;
    logic signed [CountW:0] spent;
    lcd_mode_t         mode;
    logic              mode_irq_en;
    logic              coin;

    assign s_ready = ~skid_valid_reg;
    assign accept  = s_valid & s_ready;
    assign m_valid = main_valid_reg;
    assign take    = main_valid_reg & m_ready;

    always_comb begin
        spent = $signed({1'b0, LINE_CYCLES}) - $signed({1'b0, countdown_reg});
        if (line_reg >= VBLANK_LINE) begin
            mode        = MODE_VBLANK;
            mode_irq_en = irq_enables_reg[EN_VBLANK];
        end else if (spent <= $signed({1'b0, OAM_END})) begin
            mode        = MODE_OAM;
            mode_irq_en = irq_enables_reg[EN_OAM];
        end else if (spent <= $signed({1'b0, TRANSFER_END})) begin
            mode        = MODE_TRANSFER;
            mode_irq_en = 1'b0;
        end else begin
            mode        = MODE_HBLANK;
            mode_irq_en = irq_enables_reg[EN_HBLANK];
        end
        coin = (line_reg == compare_line_reg);

        result_next.lcd_mode     = mode;
        result_next.coincidence  = coin;
        result_next.status_irq   = (mode_irq_en & (mode != prev_mode_reg))
                                   | (coin & irq_enables_reg[EN_COIN]);
        result_next.vblank_irq   = 1'b0;
        result_next.draw_strobe  = 1'b0;
        result_next.drawn_line   = '0;
        prev_mode_next           = mode;
        line_next                = line_reg;
        countdown_next           = countdown_reg - {2'b00, s_elapsed_cycles};

        if (countdown_reg <= {2'b00, s_elapsed_cycles}) begin
            countdown_next = LINE_CYCLES;
            line_next      = line_reg + 8'd1;
            if (line_reg == VBLANK_LINE) begin
                result_next.vblank_irq = 1'b1;
            end else if (line_reg > LAST_LINE) begin
                line_next = '0;
            end else if (line_reg < VBLANK_LINE) begin
                result_next.draw_strobe = 1'b1;
                result_next.drawn_line  = line_reg;
            end
        end

        if (!display_enable_reg) begin
            prev_mode_next           = MODE_VBLANK;
            countdown_next           = LINE_CYCLES;
            line_next                = '0;
            result_next.lcd_mode     = MODE_VBLANK;
            result_next.coincidence  = 1'b0;
            result_next.status_irq   = 1'b0;
            result_next.vblank_irq   = 1'b0;
            result_next.draw_strobe  = 1'b0;
            result_next.drawn_line   = '0;
        end
        result_next.current_line = line_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_enable_reg <= 1'b1;
            compare_line_reg   <= '0;
            irq_enables_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DISPLAY_ENABLE: display_enable_reg <= cfg_data[0];
                CFG_COMPARE_LINE:   compare_line_reg   <= cfg_data;
                CFG_IRQ_ENABLES:    irq_enables_reg    <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg <= '0;
            line_reg      <= '0;
            prev_mode_reg <= MODE_HBLANK;
        end else if (accept) begin
            countdown_reg <= countdown_next;
            line_reg      <= line_next;
            prev_mode_reg <= prev_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!main_valid_reg || take) begin
                main_reg       <= result_next;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= result_next;
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            main_valid_reg <= 1'b0;
        end
    end

    assign m_lcd_mode     = main_reg.lcd_mode;
    assign m_current_line = main_reg.current_line;
    assign m_coincidence  = main_reg.coincidence;
    assign m_status_irq   = main_reg.status_irq;
    assign m_vblank_irq   = main_reg.vblank_irq;
    assign m_draw_strobe  = main_reg.draw_strobe;
    assign m_drawn_line   = main_reg.drawn_line;

endmodule

// ----- verif/lcd_mode_timing_controller_unit_test.sv -----
// ============================================================================
// LCD mode timing controller testbench
// Sends instruction cycle counts through the valid/ready input channel,
// predicts mode, line, coincidence, interrupts and draw strobe for each word,
// and checks every result word in order. Idle bursts on both sides and
// register writes between phases cover several display and interrupt setups.
// ============================================================================
module lcd_mode_timing_controller_unit_test;
    import lcd_mtc_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [1:0]       cfg_index = CFG_DISPLAY_ENABLE;
    logic [7:0]       cfg_data = 8'd0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_elapsed_cycles = 8'd0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [1:0]       m_lcd_mode;
    logic [LineW-1:0] m_current_line;
    logic             m_coincidence;
    logic             m_status_irq;
    logic             m_vblank_irq;
    logic             m_draw_strobe;
    logic [LineW-1:0] m_drawn_line;

    logic              lcd_on = 1'b1;
    logic [LineW-1:0]  lyc_line = '0;
    logic [3:0]        stat_irq_mask = '0;
    logic [CountW-1:0] line_left = '0;
    logic [LineW-1:0]  line_no = '0;
    lcd_mode_t         last_mode = MODE_HBLANK;

    result_t     pending_status_q[$];
    int unsigned mismatch_count = 0;
    logic        idling_on = 1'b1;
    int unsigned ready_hold = 0;

    lcd_mode_timing_controller_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_elapsed_cycles (s_elapsed_cycles),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_lcd_mode       (m_lcd_mode),
        .m_current_line   (m_current_line),
        .m_coincidence    (m_coincidence),
        .m_status_irq     (m_status_irq),
        .m_vblank_irq     (m_vblank_irq),
        .m_draw_strobe    (m_draw_strobe),
        .m_drawn_line     (m_drawn_line)
    );

    always #5 aclk = ~aclk;

    function automatic result_t advance_timing(input logic [7:0] cycles);
        result_t          r;
        int               spent;
        int               remaining;
        logic             irq_en;
        logic [LineW-1:0] old_line;
        r = '0;
        irq_en = 1'b0;
        if (!lcd_on) begin
            line_left = LINE_CYCLES;
            line_no = '0;
            last_mode = MODE_VBLANK;
            r.lcd_mode = MODE_VBLANK;
            return r;
        end
        if (line_no >= VBLANK_LINE) begin
            r.lcd_mode = MODE_VBLANK;
            irq_en = stat_irq_mask[EN_VBLANK];
        end else begin
            spent = int'(LINE_CYCLES) - int'(line_left);
            if (spent <= int'(OAM_END)) begin
                r.lcd_mode = MODE_OAM;
                irq_en = stat_irq_mask[EN_OAM];
            end else if (spent <= int'(TRANSFER_END)) begin
                r.lcd_mode = MODE_TRANSFER;
            end else begin
                r.lcd_mode = MODE_HBLANK;
                irq_en = stat_irq_mask[EN_HBLANK];
            end
        end
        r.status_irq = irq_en && (r.lcd_mode != last_mode);
        if (line_no == lyc_line) begin
            r.coincidence = 1'b1;
            if (stat_irq_mask[EN_COIN]) begin
                r.status_irq = 1'b1;
            end
        end
        last_mode = r.lcd_mode;

        remaining = int'(line_left) - int'(cycles);
        if (remaining <= 0) begin
            old_line = line_no;
            line_no = old_line + 8'd1;
            remaining = int'(LINE_CYCLES);
            if (old_line == VBLANK_LINE) begin
                r.vblank_irq = 1'b1;
            end else if (old_line > LAST_LINE) begin
                line_no = '0;
            end else if (old_line < VBLANK_LINE) begin
                r.draw_strobe = 1'b1;
                r.drawn_line = old_line;
            end
        end
        line_left = remaining[CountW-1:0];
        r.current_line = line_no;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status_q.size() == 0) begin
                $error("result word arrived with no prediction waiting");
                mismatch_count++;
            end else begin
                exp_r = pending_status_q.pop_front();
                check_field("lcd_mode", 8'(exp_r.lcd_mode), 8'(m_lcd_mode));
                check_field("current_line", exp_r.current_line, m_current_line);
                check_field("coincidence", 8'(exp_r.coincidence), 8'(m_coincidence));
                check_field("status_irq", 8'(exp_r.status_irq), 8'(m_status_irq));
                check_field("vblank_irq", 8'(exp_r.vblank_irq), 8'(m_vblank_irq));
                check_field("draw_strobe", 8'(exp_r.draw_strobe), 8'(m_draw_strobe));
                check_field("drawn_line", exp_r.drawn_line, m_drawn_line);
            end
        end
    end

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(1, 15) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] cycles);
        int unsigned gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_elapsed_cycles <= cycles;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_status_q.push_back(advance_timing(cycles));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_status_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DISPLAY_ENABLE: lcd_on = value[0];
            CFG_COMPARE_LINE:   lyc_line = value;
            CFG_IRQ_ENABLES:    stat_irq_mask = value[3:0];
            default: ;
        endcase
    endtask

    task automatic test_first_step_after_reset();
        send_word(8'd0);
        settle();
    endtask

    task automatic test_mode_windows();
        logic [7:0] steps[$];
        steps = '{8'd0, 8'd80, 8'd1, 8'd1, 8'd170, 8'd1, 8'd255, 8'd255,
                  8'd3, 8'd255, 8'd128, 8'd255, 8'd64, 8'd15, 8'd255};
        write_reg(CFG_IRQ_ENABLES, 8'h0F);
        write_reg(CFG_COMPARE_LINE, 8'd1);
        foreach (steps[i]) begin
            send_word(steps[i]);
        end
        settle();
    endtask

    task automatic test_display_disable();
        write_reg(CFG_DISPLAY_ENABLE, 8'd0);
        send_word(8'd255);
        send_word(8'd0);
        send_word(8'd7);
        settle();
        write_reg(CFG_DISPLAY_ENABLE, 8'd1);
        send_word(8'd200);
        send_word(8'd255);
        settle();
    endtask

    task automatic test_random_frames(input int unsigned count,
                                      input logic [7:0] cmp,
                                      input logic [3:0] irqs);
        int unsigned roll;
        logic [7:0]  cycles;
        write_reg(CFG_COMPARE_LINE, cmp);
        write_reg(CFG_IRQ_ENABLES, {4'd0, irqs});
        repeat (count) begin
            roll = $urandom_range(0, 19);
            if (roll < 15) begin
                cycles = 8'($urandom_range(192, 255));
            end else if (roll < 19) begin
                cycles = 8'($urandom_range(0, 255));
            end else begin
                cycles = 8'($urandom_range(0, 15));
            end
            send_word(cycles);
        end
        settle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_step_after_reset();
        test_mode_windows();
        test_display_disable();
        test_random_frames(200, 8'd0, 4'hF);
        test_random_frames(200, VBLANK_LINE, 4'h2);
        test_random_frames(250, 8'd154, 4'h9);
        test_random_frames(200, 8'd255, 4'h5);
        test_display_disable();
        idling_on = 1'b0;
        test_random_frames(200, 8'($urandom_range(0, 160)), 4'($urandom_range(0, 15)));

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lcd_mtc_pkg.sv
rtl/lcd_mode_timing_controller_unit.sv
verif/lcd_mode_timing_controller_unit_test.sv
